/* hw/rtl/usrm_pkg.sv */
`default_nettype none

package usrm_pkg;

  localparam int BYTE_W = 8;
  localparam int LEN_W  = 4;
  localparam int DIV_W  = 7;

  localparam int RX_DEPTH_DEF = 16;
  localparam int TX_DEPTH_DEF = 16;

  // bus access and line event codes
  typedef enum logic [2:0] {
    OP_READ_DATA   = 3'd0,
    OP_READ_STATUS = 3'd1,
    OP_WRITE_DATA  = 3'd2,
    OP_WRITE_CTRL  = 3'd3,
    OP_LINE_RX     = 3'd4,
    OP_TX_PULL     = 3'd5
  } op_t;

  // command byte bits
  localparam int CMD_TXEN  = 0;
  localparam int CMD_DTR   = 1;
  localparam int CMD_RXEN  = 2;
  localparam int CMD_ERCLR = 4;
  localparam int CMD_RTS   = 5;
  localparam int CMD_IRST  = 6;

  // status byte bits
  localparam int ST_TXRDY = 0;
  localparam int ST_RXRDY = 1;
  localparam int ST_TXEMP = 2;
  localparam int ST_OVRN  = 4;
  localparam int ST_DSR   = 7;

  // mode byte baud factor codes
  localparam logic [1:0] BAUD_X16 = 2'd2;
  localparam logic [1:0] BAUD_X64 = 2'd3;

  localparam logic [DIV_W-1:0] DIV_1  = 7'd1;
  localparam logic [DIV_W-1:0] DIV_16 = 7'd16;
  localparam logic [DIV_W-1:0] DIV_64 = 7'd64;

  localparam logic [LEN_W-1:0] LEN_MIN = 4'd5;
  localparam logic [LEN_W-1:0] LEN_RST = 4'd8;

  typedef struct packed {
    logic push;
    logic pop;
  } q_ctl_t;

  typedef struct packed {
    logic              empty;
    logic              full;
    logic              single;
    logic [BYTE_W-1:0] head_data;
  } q_stat_t;

endpackage

`default_nettype wire

/* hw/rtl/usrm_if.sv */
`default_nettype none

interface usrm_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic [7:0] data;

  modport source (output valid, output mode, output data, input ready);
  modport sink   (input valid, input mode, input data, output ready);
endinterface

interface usrm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_value;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic       dtr_level;
  logic       rts_level;
  logic [3:0] char_bits;
  logic [6:0] clock_divisor;

  modport source (output valid, output read_value, output tx_valid, output tx_byte,
                  output dtr_level, output rts_level, output char_bits,
                  output clock_divisor, input ready);
  modport sink   (input valid, input read_value, input tx_valid, input tx_byte,
                  input dtr_level, input rts_level, input char_bits,
                  input clock_divisor, output ready);
endinterface

`default_nettype wire

/* hw/rtl/usart_register_model_top.sv */
`default_nettype none

// USART register model, 8251 style, seen from its bus. Each request transaction is one bus
// access or line event (data read, status read, data write, control write, byte received
// from the line, pull of a byte to send) and gives exactly one response transaction. The
// first control write after reset or after an internal reset is the mode byte (character
// length and baud factor); later control writes are command bytes. Received bytes sit in a
// holding register with a receive queue of RX_DEPTH bytes behind it; written bytes wait in a
// transmit queue of TX_DEPTH bytes until pulled. One transaction is taken every cycle while
// the request side is not stalled; each passes an input register, decode and state update,
// and a response register. A response held by a stalled receiver holds the input register,
// and the request side stalls only while both are full. The queues are memories with a
// registered head read, prefetched from the next head entry so a pop needs no wait. No
// clearing pass is needed after reset.
module usart_register_model_top #(
  parameter int RX_DEPTH = usrm_pkg::RX_DEPTH_DEF,
  parameter int TX_DEPTH = usrm_pkg::TX_DEPTH_DEF
) (
  input wire logic  clk,
  input wire logic  rst,
  usrm_in_if.sink   req,
  usrm_out_if.source rsp
);
  import usrm_pkg::*;

  // input register
  logic              s1_valid;
  op_t               s1_op;
  logic [BYTE_W-1:0] s1_data;

  // response register
  logic              out_valid;
  logic [BYTE_W-1:0] out_read_value;
  logic              out_tx_valid;
  logic [BYTE_W-1:0] out_tx_byte;
  logic              out_dtr;
  logic              out_rts;
  logic [LEN_W-1:0]  out_len;
  logic [DIV_W-1:0]  out_div;

  // architectural state
  logic              expect_mode, expect_mode_next;
  logic [LEN_W-1:0]  length_reg, length_reg_next;
  logic [DIV_W-1:0]  divisor_reg, divisor_reg_next;
  logic              tx_enable, tx_enable_next;
  logic              rx_enable, rx_enable_next;
  logic              dtr_reg, dtr_reg_next;
  logic              rts_reg, rts_reg_next;
  logic              rx_ready, rx_ready_next;
  logic              overrun_flag, overrun_flag_next;
  logic [BYTE_W-1:0] rx_holding, rx_holding_next;

  // per transaction result
  logic [BYTE_W-1:0] read_value;
  logic              tx_valid;
  logic [BYTE_W-1:0] tx_byte;

  q_ctl_t  rx_ctl, tx_ctl;
  q_stat_t rx_stat, tx_stat;

  logic advance;

  // the item in the input register moves on whenever the response register is free
  assign advance   = s1_valid && (!out_valid || rsp.ready);
  assign req.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_op   <= op_t'(req.mode);
      s1_data <= req.data;
    end
  end

  // single pass decode and state update
  always_comb begin
    expect_mode_next  = expect_mode;
    length_reg_next   = length_reg;
    divisor_reg_next  = divisor_reg;
    tx_enable_next    = tx_enable;
    rx_enable_next    = rx_enable;
    dtr_reg_next      = dtr_reg;
    rts_reg_next      = rts_reg;
    rx_ready_next     = rx_ready;
    overrun_flag_next = overrun_flag;
    rx_holding_next   = rx_holding;
    read_value        = '0;
    tx_valid          = 1'b0;
    tx_byte           = '0;
    rx_ctl            = '0;
    tx_ctl            = '0;
    if (advance) begin
      unique case (s1_op)
        OP_READ_DATA: begin
          read_value = rx_holding;
          if (!rx_stat.empty) begin
            // oldest queued byte moves up into the holding register
            rx_ctl.pop      = 1'b1;
            rx_holding_next = rx_stat.head_data;
            if (rx_stat.single) begin
              rx_ready_next = 1'b0;
            end
          end else begin
            rx_ready_next = 1'b0;
          end
        end
        OP_READ_STATUS: begin
          read_value[ST_TXRDY] = tx_enable;
          read_value[ST_RXRDY] = rx_ready && rx_enable;
          read_value[ST_TXEMP] = 1'b1;
          read_value[ST_OVRN]  = overrun_flag;
          read_value[ST_DSR]   = 1'b1;
        end
        OP_WRITE_DATA: begin
          // write to a full transmit queue is dropped
          tx_ctl.push = !tx_stat.full;
        end
        OP_WRITE_CTRL: begin
          if (expect_mode) begin
            unique case (s1_data[1:0])
              BAUD_X64: divisor_reg_next = DIV_64;
              BAUD_X16: divisor_reg_next = DIV_16;
              default:  divisor_reg_next = DIV_1;
            endcase
            length_reg_next  = LEN_MIN + LEN_W'(s1_data[3:2]);
            expect_mode_next = 1'b0;
          end else begin
            tx_enable_next = s1_data[CMD_TXEN];
            dtr_reg_next   = s1_data[CMD_DTR];
            rx_enable_next = s1_data[CMD_RXEN];
            rts_reg_next   = s1_data[CMD_RTS];
            if (s1_data[CMD_ERCLR]) begin
              overrun_flag_next = 1'b0;
            end
            // internal reset keeps dtr, rts and both queues
            if (s1_data[CMD_IRST]) begin
              expect_mode_next = 1'b1;
              tx_enable_next   = 1'b0;
              rx_enable_next   = 1'b0;
              rx_ready_next    = 1'b0;
            end
          end
        end
        OP_LINE_RX: begin
          if ((rx_ready && !rx_stat.empty) || rx_stat.full) begin
            overrun_flag_next = 1'b1;
          end
          if (!rx_ready && rx_stat.empty) begin
            // empty queue and nothing pending: byte goes straight to holding
            rx_holding_next = s1_data;
          end else begin
            rx_ctl.push = !rx_stat.full;
            if (!rx_ready) begin
              rx_ctl.pop      = 1'b1;
              rx_holding_next = rx_stat.head_data;
            end
          end
          rx_ready_next = 1'b1;
        end
        OP_TX_PULL: begin
          if (!tx_stat.empty) begin
            tx_ctl.pop = 1'b1;
            tx_valid   = 1'b1;
            tx_byte    = tx_stat.head_data;
          end
        end
        default: begin
          // unused codes leave the state alone
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expect_mode  <= 1'b1;
      length_reg   <= LEN_RST;
      divisor_reg  <= DIV_16;
      tx_enable    <= 1'b0;
      rx_enable    <= 1'b0;
      dtr_reg      <= 1'b0;
      rts_reg      <= 1'b0;
      rx_ready     <= 1'b0;
      overrun_flag <= 1'b0;
      rx_holding   <= '0;
    end else begin
      expect_mode  <= expect_mode_next;
      length_reg   <= length_reg_next;
      divisor_reg  <= divisor_reg_next;
      tx_enable    <= tx_enable_next;
      rx_enable    <= rx_enable_next;
      dtr_reg      <= dtr_reg_next;
      rts_reg      <= rts_reg_next;
      rx_ready     <= rx_ready_next;
      overrun_flag <= overrun_flag_next;
      rx_holding   <= rx_holding_next;
    end
  end

  usrm_queue #(
    .DEPTH (RX_DEPTH)
  ) u_rx_queue (
    .clk   (clk),
    .rst   (rst),
    .ctl   (rx_ctl),
    .wdata (s1_data),
    .stat  (rx_stat)
  );

  usrm_queue #(
    .DEPTH (TX_DEPTH)
  ) u_tx_queue (
    .clk   (clk),
    .rst   (rst),
    .ctl   (tx_ctl),
    .wdata (s1_data),
    .stat  (tx_stat)
  );

  // response register, loaded as the item passes; levels show the state after the item
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_read_value <= read_value;
      out_tx_valid   <= tx_valid;
      out_tx_byte    <= tx_byte;
      out_dtr        <= dtr_reg_next;
      out_rts        <= rts_reg_next;
      out_len        <= length_reg_next;
      out_div        <= divisor_reg_next;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.read_value    = out_read_value;
  assign rsp.tx_valid      = out_tx_valid;
  assign rsp.tx_byte       = out_tx_byte;
  assign rsp.dtr_level     = out_dtr;
  assign rsp.rts_level     = out_rts;
  assign rsp.char_bits     = out_len;
  assign rsp.clock_divisor = out_div;

`ifndef ASSERT_OFF
  a_write_reads_zero: assert property (@(posedge clk) disable iff (rst)
    (advance && s1_op != OP_READ_DATA && s1_op != OP_READ_STATUS) |=> (out_read_value == '0))
    else $error("nonzero read value for a non-read transaction");
  a_status_fixed: assert property (@(posedge clk) disable iff (rst)
    (advance && s1_op == OP_READ_STATUS) |=> (out_read_value[ST_DSR] && out_read_value[ST_TXEMP]))
    else $error("status byte lost its fixed bits");
  a_line_rx_ready: assert property (@(posedge clk) disable iff (rst)
    (advance && s1_op == OP_LINE_RX) |=> rx_ready)
    else $error("receive ready not set after line byte");
  a_internal_reset: assert property (@(posedge clk) disable iff (rst)
    (advance && s1_op == OP_WRITE_CTRL && !expect_mode && s1_data[CMD_IRST])
      |=> (expect_mode && !tx_enable && !rx_enable && !rx_ready))
    else $error("internal reset did not restore mode expectation");
  a_pull_only_on_pull: assert property (@(posedge clk) disable iff (rst)
    (advance && s1_op != OP_TX_PULL) |=> !out_tx_valid)
    else $error("transmit byte returned without a pull");
`endif

endmodule

`default_nettype wire

/* hw/rtl/usrm_queue.sv */
`default_nettype none

module usrm_queue #(
  parameter int DEPTH = usrm_pkg::RX_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire usrm_pkg::q_ctl_t              ctl,
  input  wire logic [usrm_pkg::BYTE_W-1:0]   wdata,
  output usrm_pkg::q_stat_t                  stat
);
  import usrm_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] head_data;
  logic [AW-1:0]     head;
  logic [AW-1:0]     head_next;
  logic [AW-1:0]     tail;
  logic [AW-1:0]     tail_next;
  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;

  always_comb begin
    head_next = head;
    tail_next = tail;
    if (ctl.pop) begin
      head_next = (head == AW'(DEPTH - 1)) ? '0 : head + 1'b1;
    end
    if (ctl.push) begin
      tail_next = (tail == AW'(DEPTH - 1)) ? '0 : tail + 1'b1;
    end
    count_next = count + CW'(ctl.push) - CW'(ctl.pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  // storage with registered read of the next head entry, bypassed on a write to it
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[tail] <= wdata;
    end
    head_data <= (ctl.push && tail == head_next) ? wdata : mem[head_next];
  end

  assign stat.empty     = (count == '0);
  assign stat.full      = (count == CW'(DEPTH));
  assign stat.single    = (count == CW'(1));
  assign stat.head_data = head_data;

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue count beyond depth");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    !(ctl.pop && count == '0))
    else $error("pop from empty queue");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    !(ctl.push && !ctl.pop && count == CW'(DEPTH)))
    else $error("push into full queue");
`endif

endmodule

`default_nettype wire

/* sim/tb_usart_register_model_top.sv */
`timescale 1ns / 100ps

module tb_usart_register_model_top;
  import usrm_pkg::*;

  localparam int RX_DEPTH  = RX_DEPTH_DEF;
  localparam int TX_DEPTH  = TX_DEPTH_DEF;
  localparam int ITEMS     = 1950;
  localparam int DRAIN_CYC = 10;
  localparam int REPORT_MAX = 10;

  // sender idle and receiver stall odds, in percent, for each phase
  localparam int SRC_IDLE [4] = '{0, 52, 0, 10};
  localparam int SNK_STALL[4] = '{0, 0, 52, 10};

  // one response transaction, field for field as the block drives it
  typedef struct packed {
    logic [7:0] read_value;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       dtr_level;
    logic       rts_level;
    logic [3:0] char_bits;
    logic [6:0] clock_divisor;
  } usart_resp_t;

  // directed stimulus row; typed rows carry their own expected response
  typedef struct packed {
    op_t         op;
    logic [7:0]  data;
    logic        typed;
    usart_resp_t resp;
  } dir_row_t;

  logic clk;
  logic rst;

  usrm_in_if  req_if ();
  usrm_out_if rsp_if ();

  usart_register_model_top #(
    .RX_DEPTH(RX_DEPTH),
    .TX_DEPTH(TX_DEPTH)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if)
  );

  // shadow copy of the usart state
  logic       await_mode_byte;
  logic [3:0] char_len;
  logic [6:0] baud_div;
  logic       tx_en;
  logic       rx_en;
  logic       dtr;
  logic       rts;
  logic       rx_avail;
  logic       overrun;
  logic [7:0] rx_hold;
  logic [7:0] rx_fifo[$];
  logic [7:0] tx_fifo[$];

  usart_resp_t expected_resp_q[$];
  dir_row_t    directed_rows[$];

  int src_idle_pct;
  int snk_stall_pct;
  int items_sent;
  int resp_checked;
  int mismatches;
  int op_count[6];
  int rx_overflows;
  int tx_drops;

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit, far beyond the slowest correct run
  initial begin
    #2000000;
    $display("timeout with %0d responses outstanding", expected_resp_q.size());
    $display("Regression FAIL");
    $finish;
  end

  function automatic usart_resp_t resp_of(logic [7:0] rv, logic txv, logic [7:0] txb,
                                          logic dtr_l, logic rts_l, logic [3:0] len,
                                          logic [6:0] div);
    usart_resp_t r;
    r.read_value    = rv;
    r.tx_valid      = txv;
    r.tx_byte       = txb;
    r.dtr_level     = dtr_l;
    r.rts_level     = rts_l;
    r.char_bits     = len;
    r.clock_divisor = div;
    return r;
  endfunction

  function automatic void add_row(op_t op, logic [7:0] d, logic typed, usart_resp_t r);
    directed_rows.push_back('{op, d, typed, r});
  endfunction

  function automatic string fmt_resp(usart_resp_t r);
    return $sformatf("rv=%02h txv=%0b txb=%02h dtr=%0b rts=%0b len=%0d div=%0d",
                     r.read_value, r.tx_valid, r.tx_byte, r.dtr_level, r.rts_level,
                     r.char_bits, r.clock_divisor);
  endfunction

  function automatic void note_fail(string msg);
    mismatches++;
    if (mismatches <= REPORT_MAX)
      $display("ERROR at %0t ns: %s", $time, msg);
  endfunction

  // computes the response to one bus access or line event and advances the shadow state
  function automatic usart_resp_t usart_predict(op_t op, logic [7:0] d);
    usart_resp_t r;
    r = '0;
    case (op)
      OP_READ_DATA: begin
        r.read_value = rx_hold;
        if (rx_fifo.size() > 0) begin
          rx_hold = rx_fifo.pop_front();
          if (rx_fifo.size() == 0)
            rx_avail = 1'b0;
        end else begin
          rx_avail = 1'b0;
        end
      end
      OP_READ_STATUS: begin
        r.read_value[ST_DSR]   = 1'b1;
        r.read_value[ST_TXEMP] = 1'b1;
        r.read_value[ST_TXRDY] = tx_en;
        r.read_value[ST_RXRDY] = rx_avail && rx_en;
        r.read_value[ST_OVRN]  = overrun;
      end
      OP_WRITE_DATA: begin
        if (tx_fifo.size() < TX_DEPTH)
          tx_fifo.push_back(d);
        else
          tx_drops++;
      end
      OP_WRITE_CTRL: begin
        if (await_mode_byte) begin
          case (d[1:0])
            BAUD_X64: baud_div = DIV_64;
            BAUD_X16: baud_div = DIV_16;
            default:  baud_div = DIV_1;
          endcase
          char_len = LEN_MIN + 4'(d[3:2]);
          await_mode_byte = 1'b0;
        end else begin
          tx_en = d[CMD_TXEN];
          dtr   = d[CMD_DTR];
          rx_en = d[CMD_RXEN];
          rts   = d[CMD_RTS];
          if (d[CMD_ERCLR])
            overrun = 1'b0;
          if (d[CMD_IRST]) begin
            // internal reset keeps dtr, rts and both queues
            await_mode_byte = 1'b1;
            tx_en    = 1'b0;
            rx_en    = 1'b0;
            rx_avail = 1'b0;
          end
        end
      end
      OP_LINE_RX: begin
        if (rx_avail && rx_fifo.size() > 0)
          overrun = 1'b1;
        if (rx_fifo.size() >= RX_DEPTH) begin
          overrun = 1'b1;
          rx_overflows++;
        end else begin
          rx_fifo.push_back(d);
        end
        if (!rx_avail && rx_fifo.size() > 0)
          rx_hold = rx_fifo.pop_front();
        rx_avail = 1'b1;
      end
      OP_TX_PULL: begin
        if (tx_fifo.size() > 0) begin
          r.tx_valid = 1'b1;
          r.tx_byte  = tx_fifo.pop_front();
        end
      end
      default: ;
    endcase
    r.dtr_level     = dtr;
    r.rts_level     = rts;
    r.char_bits     = char_len;
    r.clock_divisor = baud_div;
    return r;
  endfunction

  // offers one request transaction, idling first at random, and records its expectation
  task automatic send_item(op_t op, logic [7:0] d, logic typed, usart_resp_t typed_resp);
    usart_resp_t pred;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.mode  <= op;
    req_if.data  <= d;
    @(posedge clk);
    while (!req_if.ready)
      @(posedge clk);
    // accepted at this edge
    pred = usart_predict(op, d);
    expected_resp_q.push_back(typed ? typed_resp : pred);
    op_count[op]++;
    items_sent++;
  endtask

  // one random burst; bursts of one kind are what fill and drain the queues
  task automatic random_burst();
    int         kind;
    int         len;
    logic [7:0] d;
    kind = $urandom_range(0, 9);
    len  = $urandom_range(1, 20);
    case (kind)
      0, 1: repeat (len) send_item(OP_LINE_RX, 8'($urandom_range(0, 255)), 1'b0, '0);
      2:    repeat (len) send_item(OP_READ_DATA, 8'($urandom_range(0, 255)), 1'b0, '0);
      3:    repeat (len) send_item(OP_WRITE_DATA, 8'($urandom_range(0, 255)), 1'b0, '0);
      4:    repeat (len) send_item(OP_TX_PULL, 8'($urandom_range(0, 255)), 1'b0, '0);
      5: begin
        // command byte; now and then an internal reset followed by a fresh mode byte
        d = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 5) != 0)
          d[CMD_IRST] = 1'b0;
        send_item(OP_WRITE_CTRL, d, 1'b0, '0);
        if (d[CMD_IRST])
          send_item(OP_WRITE_CTRL, 8'($urandom_range(0, 255)), 1'b0, '0);
      end
      6:       send_item(OP_READ_STATUS, 8'($urandom_range(0, 255)), 1'b0, '0);
      default: send_item(op_t'($urandom_range(0, 5)), 8'($urandom_range(0, 255)), 1'b0, '0);
    endcase
  endtask

  // compares one response transaction with the oldest expectation
  task automatic check_resp();
    usart_resp_t got;
    usart_resp_t want;
    string       bad;
    got.read_value    = rsp_if.read_value;
    got.tx_valid      = rsp_if.tx_valid;
    got.tx_byte       = rsp_if.tx_byte;
    got.dtr_level     = rsp_if.dtr_level;
    got.rts_level     = rsp_if.rts_level;
    got.char_bits     = rsp_if.char_bits;
    got.clock_divisor = rsp_if.clock_divisor;
    resp_checked++;
    if (expected_resp_q.size() == 0) begin
      note_fail({"response with nothing expected: ", fmt_resp(got)});
    end else begin
      want = expected_resp_q.pop_front();
      bad  = "";
      if (got.read_value !== want.read_value)       bad = {bad, " read_value"};
      if (got.tx_valid !== want.tx_valid)           bad = {bad, " tx_valid"};
      if (got.tx_byte !== want.tx_byte)             bad = {bad, " tx_byte"};
      if (got.dtr_level !== want.dtr_level)         bad = {bad, " dtr_level"};
      if (got.rts_level !== want.rts_level)         bad = {bad, " rts_level"};
      if (got.char_bits !== want.char_bits)         bad = {bad, " char_bits"};
      if (got.clock_divisor !== want.clock_divisor) bad = {bad, " clock_divisor"};
      if (bad != "")
        note_fail($sformatf("response %0d wrong in%s: expected %s, got %s",
                            resp_checked, bad, fmt_resp(want), fmt_resp(got)));
    end
  endtask

  // response side: checks accepted transactions and stalls at random
  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_if.valid && rsp_if.ready)
        check_resp();
      rsp_if.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end
  end

  // main sequence
  initial begin
    rst           <= 1'b1;
    req_if.valid  <= 1'b0;
    req_if.mode   <= OP_READ_DATA;
    req_if.data   <= 8'h00;
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    items_sent    = 0;
    resp_checked  = 0;
    mismatches    = 0;
    rx_overflows  = 0;
    tx_drops      = 0;
    foreach (op_count[i])
      op_count[i] = 0;

    // shadow state as after reset
    await_mode_byte = 1'b1;
    char_len = LEN_RST;
    baud_div = DIV_16;
    tx_en    = 1'b0;
    rx_en    = 1'b0;
    dtr      = 1'b0;
    rts      = 1'b0;
    rx_avail = 1'b0;
    overrun  = 1'b0;
    rx_hold  = 8'h00;

    // reset state, then the mode byte at its extremes and an internal reset
    add_row(OP_READ_STATUS, 8'hFF, 1'b1, resp_of(8'h84, 1'b0, 8'h00, 1'b0, 1'b0, LEN_RST, DIV_16));
    add_row(OP_READ_DATA,   8'hFF, 1'b1, resp_of(8'h00, 1'b0, 8'h00, 1'b0, 1'b0, LEN_RST, DIV_16));
    // pull from an empty transmit queue
    add_row(OP_TX_PULL,     8'hFF, 1'b1, resp_of(8'h00, 1'b0, 8'h00, 1'b0, 1'b0, LEN_RST, DIV_16));
    add_row(OP_WRITE_CTRL,  8'h00, 1'b1, resp_of(8'h00, 1'b0, 8'h00, 1'b0, 1'b0, LEN_MIN, DIV_1));
    // every command bit at once, internal reset among them
    add_row(OP_WRITE_CTRL,  8'hFF, 1'b1, resp_of(8'h00, 1'b0, 8'h00, 1'b1, 1'b1, LEN_MIN, DIV_1));
    add_row(OP_READ_STATUS, 8'h00, 1'b1, resp_of(8'h84, 1'b0, 8'h00, 1'b1, 1'b1, LEN_MIN, DIV_1));
    add_row(OP_WRITE_CTRL,  8'hFF, 1'b1, resp_of(8'h00, 1'b0, 8'h00, 1'b1, 1'b1, LEN_RST, DIV_64));
    add_row(OP_WRITE_CTRL,  8'h27, 1'b1, resp_of(8'h00, 1'b0, 8'h00, 1'b1, 1'b1, LEN_RST, DIV_64));
    add_row(OP_READ_STATUS, 8'h00, 1'b1, resp_of(8'h85, 1'b0, 8'h00, 1'b1, 1'b1, LEN_RST, DIV_64));
    // third byte arrives while data is pending: overrun
    add_row(OP_LINE_RX,     8'h00, 1'b0, '0);
    add_row(OP_LINE_RX,     8'hFF, 1'b0, '0);
    add_row(OP_LINE_RX,     8'hA5, 1'b0, '0);
    add_row(OP_READ_STATUS, 8'h00, 1'b1, resp_of(8'h97, 1'b0, 8'h00, 1'b1, 1'b1, LEN_RST, DIV_64));
    add_row(OP_READ_DATA,   8'h00, 1'b0, '0);
    add_row(OP_READ_DATA,   8'h00, 1'b0, '0);
    add_row(OP_READ_DATA,   8'h00, 1'b0, '0);
    // error clear alone drops dtr and rts
    add_row(OP_WRITE_CTRL,  8'h10, 1'b1, resp_of(8'h00, 1'b0, 8'h00, 1'b0, 1'b0, LEN_RST, DIV_64));
    add_row(OP_WRITE_DATA,  8'h00, 1'b1, resp_of(8'h00, 1'b0, 8'h00, 1'b0, 1'b0, LEN_RST, DIV_64));
    add_row(OP_WRITE_DATA,  8'hFF, 1'b1, resp_of(8'h00, 1'b0, 8'h00, 1'b0, 1'b0, LEN_RST, DIV_64));
    add_row(OP_TX_PULL,     8'h00, 1'b1, resp_of(8'h00, 1'b1, 8'h00, 1'b0, 1'b0, LEN_RST, DIV_64));
    add_row(OP_TX_PULL,     8'h00, 1'b1, resp_of(8'h00, 1'b1, 8'hFF, 1'b0, 1'b0, LEN_RST, DIV_64));
    add_row(OP_TX_PULL,     8'h00, 1'b1, resp_of(8'h00, 1'b0, 8'h00, 1'b0, 1'b0, LEN_RST, DIV_64));
    // internal reset alone, then a mid-range mode byte
    add_row(OP_WRITE_CTRL,  8'h40, 1'b1, resp_of(8'h00, 1'b0, 8'h00, 1'b0, 1'b0, LEN_RST, DIV_64));
    add_row(OP_WRITE_CTRL,  8'h09, 1'b1, resp_of(8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 4'd7, DIV_1));
    add_row(OP_READ_STATUS, 8'h00, 1'b1, resp_of(8'h84, 1'b0, 8'h00, 1'b0, 1'b0, 4'd7, DIV_1));

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (int ph = 0; ph < 4; ph++) begin
      src_idle_pct  = SRC_IDLE[ph];
      snk_stall_pct = SNK_STALL[ph];
      if (ph == 0) begin
        foreach (directed_rows[i])
          send_item(directed_rows[i].op, directed_rows[i].data, directed_rows[i].typed,
                    directed_rows[i].resp);
      end
      while (items_sent < (ph + 1) * ITEMS / 4)
        random_burst();
    end
    req_if.valid <= 1'b0;

    // drain; a stuck block is caught by the run limit
    while (expected_resp_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    $display("%0d transactions over four idling phases: %0d data reads, %0d status reads,",
             items_sent, op_count[OP_READ_DATA], op_count[OP_READ_STATUS]);
    $display("  %0d data writes, %0d control writes, %0d line bytes, %0d pulls;",
             op_count[OP_WRITE_DATA], op_count[OP_WRITE_CTRL], op_count[OP_LINE_RX],
             op_count[OP_TX_PULL]);
    $display("  %0d rx overflows, %0d tx drops", rx_overflows, tx_drops);
    if (mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
